FILE: hdl/pva_pkg.sv
// ----------------------------------------------------------------------------
// pva_pkg
// Shared types and constants for the priority voice allocator.
// ----------------------------------------------------------------------------
package pva_pkg;

    localparam int CHANNELS   = 3;
    localparam int CHAN_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int PRIO_W     = 7;
    localparam int SOUND_W    = 8;
    localparam int MASK_W     = 3;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 8;

    localparam logic [PRIO_W-1:0] PRIO_TOP = 7'd127;
    localparam logic [PRIO_W-1:0] PRIO_SAT = 7'd126;

    localparam logic OP_PLAY   = 1'b0;
    localparam logic OP_STATUS = 1'b1;

    typedef logic [CHANNELS-1:0][PRIO_W-1:0]  prio_arr_t;
    typedef logic [CHANNELS-1:0][SOUND_W-1:0] sound_arr_t;

    typedef struct packed {
        logic               op;
        logic [SOUND_W-1:0] sound_id;
        logic [PRIO_W-1:0]  prio;
        logic [MASK_W-1:0]  mask;
    } item_t;

    typedef struct packed {
        logic                  take;
        logic [CHAN_IDX_W-1:0] idx;
        logic                  dropped;
        logic [CHANNELS-1:0]   clear;
        logic [PRIO_W-1:0]     prio_store;
        logic [SOUND_W-1:0]    sound_id;
    } dec_t;

    function automatic logic [1:0] chan_field(input logic [CHAN_IDX_W-1:0] idx);
        logic [15:0] wide;
        wide = 16'(idx);
        return wide[1:0];
    endfunction

endpackage

FILE: hdl/pva_decide.sv
// ----------------------------------------------------------------------------
// pva_decide
// Combinational: free slot, else steal, else drop (effects on); status frees.
// ----------------------------------------------------------------------------
module pva_decide (
    input  pva_pkg::item_t     item,
    input  logic               effects_enabled,
    input  pva_pkg::prio_arr_t slot_prio,
    input  pva_pkg::sound_arr_t slot_sound,
    output pva_pkg::dec_t      dec
);
    import pva_pkg::*;

    logic [PRIO_W-1:0]     prio_sat;
    logic [15:0]           mask_ext;
    logic                  free_any;
    logic                  steal_any;
    logic [CHAN_IDX_W-1:0] free_idx;
    logic [CHAN_IDX_W-1:0] steal_idx;

    always_comb
    begin
        prio_sat  = (item.prio == PRIO_TOP) ? PRIO_SAT : item.prio;
        mask_ext  = 16'(item.mask);
        free_any  = 1'b0;
        steal_any = 1'b0;
        free_idx  = '0;
        steal_idx = '0;
        for (int i = CHANNELS - 1; i >= 0; i--)
        begin
            if (slot_prio[i] == '0)
            begin
                free_any = 1'b1;
                free_idx = CHAN_IDX_W'(i);
            end
            if ((prio_sat >= slot_prio[i]) && (slot_sound[i] != item.sound_id))
            begin
                steal_any = 1'b1;
                steal_idx = CHAN_IDX_W'(i);
            end
        end

        dec            = '0;
        dec.prio_store = prio_sat + 7'd1;
        dec.sound_id   = item.sound_id;
        if (item.op == OP_STATUS)
        begin
            for (int i = 0; i < CHANNELS; i++)
                dec.clear[i] = ~mask_ext[i];
        end
        else if (effects_enabled)
        begin
            if (free_any)
            begin
                dec.take = 1'b1;
                dec.idx  = free_idx;
            end
            else if (steal_any)
            begin
                dec.take = 1'b1;
                dec.idx  = steal_idx;
            end
            else
                dec.dropped = 1'b1;
        end
    end

endmodule

FILE: hdl/pva_slots.sv
// ----------------------------------------------------------------------------
// pva_slots
// Channel state: stored priority plus one (0 = free) and sound id.
// ----------------------------------------------------------------------------
module pva_slots (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                update,
    input  pva_pkg::dec_t       dec,
    output pva_pkg::prio_arr_t  slot_prio,
    output pva_pkg::sound_arr_t slot_sound
);
    import pva_pkg::*;

    prio_arr_t  prio_reg;
    prio_arr_t  prio_next;
    sound_arr_t sound_reg;
    sound_arr_t sound_next;

    always_comb
    begin
        prio_next  = prio_reg;
        sound_next = sound_reg;
        if (update)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                if (dec.clear[i])
                    prio_next[i] = '0;
            end
            if (dec.take)
            begin
                prio_next[dec.idx]  = dec.prio_store;
                sound_next[dec.idx] = dec.sound_id;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prio_reg  <= '0;
            sound_reg <= '0;
        end
        else
        begin
            prio_reg  <= prio_next;
            sound_reg <= sound_next;
        end
    end

    assign slot_prio  = prio_reg;
    assign slot_sound = sound_reg;

`ifndef SYNTHESIS
    a_take_occupies: assert property (@(posedge clk) disable iff (!rst_n)
        (update && dec.take) |=> (prio_reg[$past(dec.idx)] != '0))
        else $error("taken channel not marked busy");

    a_clear_frees: assert property (@(posedge clk) disable iff (!rst_n)
        (update && !dec.take && dec.clear[0]) |=> (prio_reg[0] == '0))
        else $error("cleared channel 0 still busy");

    a_take_no_clear: assert property (@(posedge clk) disable iff (!rst_n)
        update |-> !(dec.take && (dec.clear != '0)))
        else $error("take and clear in one request");
`endif

endmodule

FILE: hdl/priority_voice_allocator_unit.sv
// ----------------------------------------------------------------------------
// priority_voice_allocator_unit
// Assigns sound play requests to playback channels, stealing if needed.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on the s_t* stream. s_tuser = 0 is a play request
//   (sound id, priority), s_tuser = 1 a status update carrying a mask of
//   channels still playing. Exactly one result per request leaves on the
//   m_t* stream: started, channel, dropped.
//   cfg_we/cfg_wdata write effects_enabled (reset 1); write only when idle.
//   An accepted request waits in the input register; its result is then
//   registered in the result register, which drives m_tvalid. Throughput: one
//   request per cycle while results are taken, set by the combinational
//   channel decision between the input register and the result register.
//   Reset frees every channel and empties both registers.
//   When m_tready is low the result holds; an empty input register still
//   takes one more request, then s_tready falls until the result is taken.
// ----------------------------------------------------------------------------
module priority_voice_allocator_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [7:0] sound_id, [14:8] priority_req, [17:15] playing_mask
    input  logic [pva_pkg::IN_DATA_W-1:0]  s_tdata,
    // [0] operation
    input  logic                           s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [0] started, [2:1] channel, [3] dropped
    output logic [pva_pkg::OUT_DATA_W-1:0] m_tdata,
    input  logic                           cfg_we,
    input  logic                           cfg_wdata
);
    import pva_pkg::*;

    logic       enable_reg;
    logic       in_valid_reg;
    item_t      in_item_reg;
    logic       out_valid_reg;
    logic       started_reg;
    logic [1:0] channel_reg;
    logic       dropped_reg;

    logic       advance;
    logic       fire;
    item_t      s_item;
    prio_arr_t  slot_prio;
    sound_arr_t slot_sound;
    dec_t       dec;

    assign advance  = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    assign s_item.op       = s_tuser;
    assign s_item.sound_id = s_tdata[7:0];
    assign s_item.prio     = s_tdata[14:8];
    assign s_item.mask     = s_tdata[17:15];

    pva_decide u_decide (
        .item            (in_item_reg),
        .effects_enabled (enable_reg),
        .slot_prio       (slot_prio),
        .slot_sound      (slot_sound),
        .dec             (dec)
    );

    pva_slots u_slots (
        .clk        (clk),
        .rst_n      (rst_n),
        .update     (fire),
        .dec        (dec),
        .slot_prio  (slot_prio),
        .slot_sound (slot_sound)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg    <= 1'b1;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                enable_reg <= cfg_wdata;
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (advance)
                out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            in_item_reg <= s_item;
        if (fire)
        begin
            started_reg <= dec.take;
            channel_reg <= dec.take ? chan_field(dec.idx) : 2'd0;
            dropped_reg <= dec.dropped;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, dropped_reg, channel_reg, started_reg};

`ifndef SYNTHESIS
    a_result_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(started_reg && dropped_reg))
        else $error("result both started and dropped");

    a_status_no_start: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && in_item_reg.op == OP_STATUS) |=> (!started_reg && !dropped_reg))
        else $error("status request produced a start or drop");

    a_hold_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |=> in_valid_reg)
        else $error("pending request lost under stall");

    a_disabled_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && !enable_reg) |-> !dec.take)
        else $error("channel taken while effects disabled");
`endif

endmodule

FILE: sim/priority_voice_allocator_unit_test.sv
// ----------------------------------------------------------------------------
// priority_voice_allocator_unit_test
// Self-checking bench for the priority voice allocator.
//
// A queue of requests feeds a stream driver. On each accepted request, a
// channel-state model predicts the grant, the steal or the drop. The monitor
// compares every result against the oldest prediction. Phases cover directed
// corner cases, effects switched off, and random traffic with source gaps and
// sink back-pressure.
// ----------------------------------------------------------------------------
module priority_voice_allocator_unit_test;

    timeunit 1ns;
    timeprecision 1ps;

    import pva_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int MAX_REPORTS    = 10;

    typedef struct packed {
        logic       started;
        logic [1:0] channel;
        logic       dropped;
    } grant_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic                  s_tuser   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_we    = 1'b0;
    logic                  cfg_wdata = 1'b0;

    // channel state as seen by the checker
    logic [PRIO_W-1:0]  voice_prio  [CHANNELS];
    logic [SOUND_W-1:0] voice_sound [CHANNELS];
    logic               fx_enabled = 1'b1;

    item_t  pending_requests [$];
    grant_t expected_grants  [$];
    item_t  offer;
    grant_t seen;
    grant_t want;

    int idle_pct  = 0;
    int stall_pct = 0;
    int fail_count = 0;
    int n_play     = 0;
    int n_status   = 0;
    int n_started  = 0;
    int n_dropped  = 0;

    priority_voice_allocator_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic grant_t predict_allocation(input item_t req);
        grant_t            g;
        logic [PRIO_W-1:0] p;
        logic [PRIO_W-1:0] held;
        bit                playing;
        g = '0;
        if (req.op == OP_STATUS)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                playing = (i < MASK_W) ? req.mask[i] : 1'b0;
                if (!playing)
                    voice_prio[i] = '0;
            end
            return g;
        end
        if (!fx_enabled)
            return g;
        p = (req.prio == PRIO_TOP) ? PRIO_SAT : req.prio;
        for (int i = 0; i < CHANNELS; i++)
        begin
            if (voice_prio[i] == '0)
            begin
                voice_prio[i]  = p + 1'b1;
                voice_sound[i] = req.sound_id;
                g.started = 1'b1;
                g.channel = 2'(i);
                return g;
            end
        end
        // all busy: steal a strictly weaker voice playing another sound
        for (int i = 0; i < CHANNELS; i++)
        begin
            held = voice_prio[i] - 1'b1;
            if (p > held && voice_sound[i] != req.sound_id)
            begin
                voice_prio[i]  = p + 1'b1;
                voice_sound[i] = req.sound_id;
                g.started = 1'b1;
                g.channel = 2'(i);
                return g;
            end
        end
        g.dropped = 1'b1;
        return g;
    endfunction

    function automatic item_t make_random_request();
        item_t r;
        r.op       = ($urandom_range(99) < 20) ? OP_STATUS : OP_PLAY;
        r.sound_id = ($urandom_range(1) == 0) ? SOUND_W'($urandom_range(3))
                                              : SOUND_W'($urandom_range(255));
        case ($urandom_range(9))
            0:       r.prio = PRIO_TOP;
            1:       r.prio = '0;
            default: r.prio = PRIO_W'($urandom_range(127));
        endcase
        r.mask = MASK_W'($urandom_range(7));
        return r;
    endfunction

    task automatic push_req(input logic op, input int id, input int prio, input int mask);
        item_t r;
        r.op       = op;
        r.sound_id = SOUND_W'(id);
        r.prio     = PRIO_W'(prio);
        r.mask     = MASK_W'(mask);
        pending_requests.push_back(r);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        while (pending_requests.size() != 0 || s_tvalid || expected_grants.size() != 0)
            @(negedge clk);
    endtask

    task automatic set_effects(input logic on);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= on;
        @(posedge clk);
        cfg_we     <= 1'b0;
        fx_enabled  = on;
    endtask

    // two batches with a full drain between them
    task automatic run_random(input int n, input int idle, input int stall);
        idle_pct  = idle;
        stall_pct = stall;
        for (int b = 0; b < 2; b++)
        begin
            for (int k = 0; k < n / 2; k++)
                pending_requests.push_back(make_random_request());
            wait_drained();
        end
    endtask

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("%0t: %s", $realtime, msg);
    endtask

    // driver
    always @(posedge clk)
    begin
        if (!rst_n)
            s_tvalid <= 1'b0;
        else
        begin
            if (s_tvalid && s_tready)
            begin
                expected_grants.push_back(predict_allocation(offer));
                if (offer.op == OP_STATUS)
                    n_status++;
                else
                    n_play++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (pending_requests.size() != 0 && $urandom_range(99) >= idle_pct)
                begin
                    offer     = pending_requests.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= IN_DATA_W'({offer.mask, offer.prio, offer.sound_id});
                    s_tuser  <= offer.op;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                seen.started = m_tdata[0];
                seen.channel = m_tdata[2:1];
                seen.dropped = m_tdata[3];
                n_started += seen.started;
                n_dropped += seen.dropped;
                if (expected_grants.size() == 0)
                    note_failure($sformatf("unexpected result started=%0b channel=%0d dropped=%0b",
                                           seen.started, seen.channel, seen.dropped));
                else
                begin
                    want = expected_grants.pop_front();
                    if (seen.started !== want.started || seen.channel !== want.channel ||
                        seen.dropped !== want.dropped)
                        note_failure($sformatf({"result mismatch: expected started=%0b ",
                                                "channel=%0d dropped=%0b, got started=%0b ",
                                                "channel=%0d dropped=%0b"},
                                               want.started, want.channel, want.dropped,
                                               seen.started, seen.channel, seen.dropped));
                end
            end
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        for (int i = 0; i < CHANNELS; i++)
        begin
            voice_prio[i]  = '0;
            voice_sound[i] = '0;
        end
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        set_effects(1'b1);

        // fill, equal priority, same sound, saturation, steals, frees
        push_req(OP_PLAY,     0,   0, 7);
        push_req(OP_PLAY,     0,   0, 0);
        push_req(OP_PLAY,     0,   0, 5);
        push_req(OP_PLAY,     1,   0, 2);
        push_req(OP_PLAY,     0, 127, 7);
        push_req(OP_PLAY,   255, 127, 0);
        push_req(OP_PLAY,   255, 126, 7);
        push_req(OP_PLAY,     7, 126, 1);
        push_req(OP_PLAY,     8, 127, 6);
        push_req(OP_STATUS, 255, 127, 2);
        push_req(OP_PLAY,     8,   5, 0);
        push_req(OP_PLAY,     9,   5, 7);
        push_req(OP_STATUS,   0,   0, 7);
        push_req(OP_PLAY,    10,   6, 3);
        push_req(OP_PLAY,    11,   6, 4);
        push_req(OP_STATUS, 170,  85, 0);
        push_req(OP_PLAY,   255, 127, 0);
        push_req(OP_STATUS,   0,   0, 4);
        push_req(OP_PLAY,    85,  42, 7);
        push_req(OP_STATUS,  15,  99, 1);
        wait_drained();

        // effects off: plays leave the channels alone, status still frees
        set_effects(1'b0);
        push_req(OP_PLAY,   255, 127, 7);
        push_req(OP_PLAY,     0,   0, 0);
        push_req(OP_STATUS, 255, 127, 3);
        push_req(OP_PLAY,    85,  64, 5);
        run_random(20, 15, 15);
        set_effects(1'b1);
        push_req(OP_PLAY,   200,  50, 0);
        wait_drained();

        run_random(100,  0,  0);
        run_random(100, 76,  0);
        run_random(100,  0, 76);
        run_random(100, 15, 15);

        repeat (6) @(posedge clk);
        $display("Covered %0d play and %0d status requests over idle, gap and stall phases,",
                 n_play, n_status);
        $display("effects on and off; %0d grants and %0d drops checked.", n_started, n_dropped);
        if (fail_count == 0 && expected_grants.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

FILE: sim.f
hdl/pva_pkg.sv
hdl/pva_decide.sv
hdl/pva_slots.sv
hdl/priority_voice_allocator_unit.sv
sim/priority_voice_allocator_unit_test.sv
